@@ rtl/core/ct_pkg.sv @@
// Shared types, constants and helpers of the sparse matrix transpose block.
package ct_pkg;

  localparam int MaxDim = 1024;
  localparam int MaxNnz = 4096;
  localparam int DimW   = $clog2(MaxDim);      // column/row index
  localparam int NnzW   = $clog2(MaxNnz);      // entry index
  localparam int CntW   = $clog2(MaxNnz) + 1;  // counts up to MaxNnz
  localparam int RegW   = 11;                  // configuration register width
  localparam int IdxW   = 1;                   // configuration register index

  localparam logic [IdxW-1:0] REG_ROW_COUNT = 1'b0;
  localparam logic [IdxW-1:0] REG_COL_COUNT = 1'b1;

  typedef enum logic [1:0] {
    OP_LOAD     = 2'd0,
    OP_FETCH    = 2'd1,
    OP_READ_PTR = 2'd2,
    OP_CLEAR    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_PAST_END = 2'd2,
    ST_RANGE    = 2'd3
  } status_t;

  typedef struct packed {
    op_t         op;
    logic [9:0]  row_index;
    logic [9:0]  col_index;
    logic [63:0] value_bits;
    logic [10:0] query_row;
  } in_t;

  typedef struct packed {
    logic [9:0]  out_row;
    logic [9:0]  out_col;
    logic [63:0] out_value;
    logic [12:0] row_pointer;
    logic        last_entry;
    status_t     status;
  } out_t;

  typedef enum logic [3:0] {
    S_CLR,
    S_IDLE,
    S_LD_WR,
    S_PFX_RD,
    S_PFX_WR,
    S_B0,
    S_B1,
    S_B2,
    S_EXEC,
    S_F_PL,
    S_F_EN,
    S_Q_RD
  } state_t;

  // Dimension register saturated to the largest supported size
  function automatic logic [RegW-1:0] sat_dim(input logic [RegW-1:0] v);
    logic [RegW-1:0] lim;
    lim = RegW'(MaxDim);
    return (v > lim) ? lim : v;
  endfunction

endpackage

@@ rtl/core/ct_front.sv @@
// Front end: accepts input beats and queues them for the execution back end.
module ct_front (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  ct_pkg::in_t in_data,
  output logic        q_valid,
  input  logic        q_ready,
  output ct_pkg::in_t q_data
);

  ct_pkg::in_t slot [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  fill;
  logic        push;
  logic        pop;

  assign in_ready = (fill != 2'd2);
  assign q_valid  = (fill != 2'd0);
  assign q_data   = slot[rd_ptr];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  // Two-slot queue, pointer control
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      case ({push, pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

  // Payload slots
  always_ff @(posedge clk) begin
    if (push) slot[wr_ptr] <= in_data;
  end

endmodule

@@ rtl/core/ct_back.sv @@
// Back end: entry store, column counts, build pass, fetch and pointer reads.
module ct_back (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [ct_pkg::IdxW-1:0]    cfg_index,
  input  logic [ct_pkg::RegW-1:0]    cfg_data,
  input  logic                       q_valid,
  output logic                       q_ready,
  input  ct_pkg::in_t                q_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output ct_pkg::out_t               out_data
);

  localparam int EntW = 2 * ct_pkg::DimW + 64;

  // Memories
  logic [EntW-1:0]          ent_mem  [ct_pkg::MaxNnz];
  logic [ct_pkg::CntW-1:0]  cnt_mem  [ct_pkg::MaxDim];
  logic [ct_pkg::CntW-1:0]  rs_mem   [ct_pkg::MaxDim];
  logic [ct_pkg::CntW-1:0]  fill_mem [ct_pkg::MaxDim];
  logic [ct_pkg::NnzW-1:0]  pl_mem   [ct_pkg::MaxNnz];

  logic                     ent_we;
  logic [ct_pkg::NnzW-1:0]  ent_waddr, ent_raddr;
  logic [EntW-1:0]          ent_wdata, ent_rdata;
  logic                     cnt_we;
  logic [ct_pkg::DimW-1:0]  cnt_waddr, cnt_raddr;
  logic [ct_pkg::CntW-1:0]  cnt_wdata, cnt_rdata;
  logic                     rs_we;
  logic [ct_pkg::DimW-1:0]  rs_waddr, rs_raddr;
  logic [ct_pkg::CntW-1:0]  rs_wdata, rs_rdata;
  logic                     fill_we;
  logic [ct_pkg::DimW-1:0]  fill_waddr, fill_raddr;
  logic [ct_pkg::CntW-1:0]  fill_wdata, fill_rdata;
  logic                     pl_we;
  logic [ct_pkg::NnzW-1:0]  pl_waddr, pl_raddr;
  logic [ct_pkg::NnzW-1:0]  pl_wdata, pl_rdata;

  // Control and working registers
  ct_pkg::state_t           state, state_next;
  logic [ct_pkg::RegW-1:0]  row_count, row_count_next;
  logic [ct_pkg::RegW-1:0]  col_count, col_count_next;
  logic [ct_pkg::CntW-1:0]  loaded, loaded_next;
  logic [ct_pkg::CntW-1:0]  cursor, cursor_next;
  logic                     built, built_next;
  logic [ct_pkg::DimW-1:0]  cidx, cidx_next;
  logic [ct_pkg::CntW-1:0]  eidx, eidx_next;
  logic [ct_pkg::CntW-1:0]  acc, acc_next;
  logic [ct_pkg::DimW-1:0]  bcol, bcol_next;
  ct_pkg::in_t              cur, cur_next;
  logic                     res_valid;
  logic                     res_set;
  ct_pkg::out_t             res, res_next;

  logic [ct_pkg::RegW-1:0]  n_rows, n_cols;
  logic [ct_pkg::CntW-1:0]  pfx_sum;
  logic [ct_pkg::DimW-1:0]  ent_col;

  assign n_rows    = ct_pkg::sat_dim(row_count);
  assign n_cols    = ct_pkg::sat_dim(col_count);
  assign ent_col   = ent_rdata[64 +: ct_pkg::DimW];
  assign pfx_sum   = acc + (({1'b0, cidx} < n_cols) ? cnt_rdata : '0);
  assign out_valid = res_valid;
  assign out_data  = res;

  // Memory ports: one write, one registered read each
  always_ff @(posedge clk) begin
    if (ent_we)  ent_mem[ent_waddr]   <= ent_wdata;
    if (cnt_we)  cnt_mem[cnt_waddr]   <= cnt_wdata;
    if (rs_we)   rs_mem[rs_waddr]     <= rs_wdata;
    if (fill_we) fill_mem[fill_waddr] <= fill_wdata;
    if (pl_we)   pl_mem[pl_waddr]     <= pl_wdata;
    ent_rdata  <= ent_mem[ent_raddr];
    cnt_rdata  <= cnt_mem[cnt_raddr];
    rs_rdata   <= rs_mem[rs_raddr];
    fill_rdata <= fill_mem[fill_raddr];
    pl_rdata   <= pl_mem[pl_raddr];
  end

  // State and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ct_pkg::S_CLR;
      row_count <= ct_pkg::RegW'(ct_pkg::MaxDim);
      col_count <= ct_pkg::RegW'(ct_pkg::MaxDim);
      loaded    <= '0;
      cursor    <= '0;
      built     <= 1'b0;
      cidx      <= '0;
      eidx      <= '0;
      acc       <= '0;
      res_valid <= 1'b0;
    end else begin
      state     <= state_next;
      row_count <= row_count_next;
      col_count <= col_count_next;
      loaded    <= loaded_next;
      cursor    <= cursor_next;
      built     <= built_next;
      cidx      <= cidx_next;
      eidx      <= eidx_next;
      acc       <= acc_next;
      if (res_set)        res_valid <= 1'b1;
      else if (out_ready) res_valid <= 1'b0;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    cur  <= cur_next;
    bcol <= bcol_next;
    if (res_set) res <= res_next;
  end

  // Sequencer: next state, memory strobes and results
  always_comb begin
    state_next     = state;
    row_count_next = row_count;
    col_count_next = col_count;
    loaded_next    = loaded;
    cursor_next    = cursor;
    built_next     = built;
    cidx_next      = cidx;
    eidx_next      = eidx;
    acc_next       = acc;
    bcol_next      = bcol;
    cur_next       = cur;
    res_set        = 1'b0;
    res_next       = '0;
    q_ready        = 1'b0;
    ent_we     = 1'b0;
    ent_waddr  = q_data.op == ct_pkg::OP_LOAD ? loaded[ct_pkg::NnzW-1:0] : '0;
    ent_wdata  = {q_data.row_index, q_data.col_index, q_data.value_bits};
    ent_raddr  = eidx[ct_pkg::NnzW-1:0];
    cnt_we     = 1'b0;
    cnt_waddr  = cidx;
    cnt_wdata  = '0;
    cnt_raddr  = cidx;
    rs_we      = 1'b0;
    rs_waddr   = cidx;
    rs_wdata   = pfx_sum;
    rs_raddr   = '0;
    fill_we    = 1'b0;
    fill_waddr = cidx;
    fill_wdata = pfx_sum;
    fill_raddr = ent_col;
    pl_we      = 1'b0;
    pl_waddr   = '0;
    pl_wdata   = eidx[ct_pkg::NnzW-1:0];
    pl_raddr   = cursor[ct_pkg::NnzW-1:0];

    case (state)
      // Zero the column counts, one per cycle
      ct_pkg::S_CLR: begin
        cnt_we = 1'b1;
        cidx_next = cidx + 1'b1;
        if (cidx == ct_pkg::DimW'(ct_pkg::MaxDim - 1)) state_next = ct_pkg::S_IDLE;
      end

      ct_pkg::S_IDLE: begin
        if (!res_valid && q_valid) begin
          q_ready  = 1'b1;
          cur_next = q_data;
          case (q_data.op)
            ct_pkg::OP_LOAD: begin
              if ({1'b0, q_data.row_index} >= n_rows ||
                  {1'b0, q_data.col_index} >= n_cols) begin
                res_set         = 1'b1;
                res_next.status = ct_pkg::ST_RANGE;
              end else if (loaded == ct_pkg::CntW'(ct_pkg::MaxNnz)) begin
                res_set         = 1'b1;
                res_next.status = ct_pkg::ST_FULL;
              end else begin
                ent_we     = 1'b1;
                cnt_raddr  = q_data.col_index;
                state_next = ct_pkg::S_LD_WR;
              end
            end
            ct_pkg::OP_FETCH, ct_pkg::OP_READ_PTR: begin
              if (built) begin
                state_next = ct_pkg::S_EXEC;
              end else begin
                cidx_next  = '0;
                acc_next   = '0;
                state_next = ct_pkg::S_PFX_RD;
              end
            end
            default: begin
              res_set         = 1'b1;
              res_next.status = ct_pkg::ST_OK;
              loaded_next     = '0;
              cursor_next     = '0;
              built_next      = 1'b0;
              cidx_next       = '0;
              state_next      = ct_pkg::S_CLR;
            end
          endcase
        end
      end

      // Bump the column count read at accept
      ct_pkg::S_LD_WR: begin
        cnt_we          = 1'b1;
        cnt_waddr       = cur.col_index;
        cnt_wdata       = cnt_rdata + 1'b1;
        loaded_next     = loaded + 1'b1;
        built_next      = 1'b0;
        cursor_next     = '0;
        res_set         = 1'b1;
        res_next.status = ct_pkg::ST_OK;
        state_next      = ct_pkg::S_IDLE;
      end

      // Prefix sum over column counts
      ct_pkg::S_PFX_RD: begin
        state_next = ct_pkg::S_PFX_WR;
      end

      ct_pkg::S_PFX_WR: begin
        rs_we     = 1'b1;
        fill_we   = 1'b1;
        acc_next  = pfx_sum;
        cidx_next = cidx + 1'b1;
        if (cidx == ct_pkg::DimW'(ct_pkg::MaxDim - 1)) begin
          eidx_next  = '0;
          state_next = ct_pkg::S_B0;
        end else begin
          state_next = ct_pkg::S_PFX_RD;
        end
      end

      // Placement pass: read entry, read fill pointer, place
      ct_pkg::S_B0: begin
        if (eidx == loaded) begin
          built_next  = 1'b1;
          cursor_next = '0;
          state_next  = ct_pkg::S_EXEC;
        end else begin
          state_next = ct_pkg::S_B1;
        end
      end

      ct_pkg::S_B1: begin
        bcol_next = ent_col;
        if ({1'b0, ent_col} >= n_cols) begin
          eidx_next  = eidx + 1'b1;
          state_next = ct_pkg::S_B0;
        end else begin
          state_next = ct_pkg::S_B2;
        end
      end

      ct_pkg::S_B2: begin
        if (fill_rdata != '0) begin
          fill_we    = 1'b1;
          fill_waddr = bcol;
          fill_wdata = fill_rdata - 1'b1;
          pl_we      = 1'b1;
          pl_waddr   = ct_pkg::NnzW'(fill_rdata - 1'b1);
        end
        eidx_next  = eidx + 1'b1;
        state_next = ct_pkg::S_B0;
      end

      ct_pkg::S_EXEC: begin
        if (cur.op == ct_pkg::OP_FETCH) begin
          if (cursor >= loaded) begin
            res_set         = 1'b1;
            res_next.status = ct_pkg::ST_PAST_END;
            state_next      = ct_pkg::S_IDLE;
          end else begin
            state_next = ct_pkg::S_F_PL;
          end
        end else begin
          if (cur.query_row > n_cols) begin
            res_set         = 1'b1;
            res_next.status = ct_pkg::ST_RANGE;
            state_next      = ct_pkg::S_IDLE;
          end else if (cur.query_row == '0) begin
            res_set         = 1'b1;
            res_next.status = ct_pkg::ST_OK;
            state_next      = ct_pkg::S_IDLE;
          end else begin
            rs_raddr   = ct_pkg::DimW'(cur.query_row - 1'b1);
            state_next = ct_pkg::S_Q_RD;
          end
        end
      end

      // Placement slot read, then entry read
      ct_pkg::S_F_PL: begin
        ent_raddr  = pl_rdata;
        state_next = ct_pkg::S_F_EN;
      end

      ct_pkg::S_F_EN: begin
        res_set             = 1'b1;
        res_next.out_row    = ent_col;
        res_next.out_col    = ent_rdata[64 + ct_pkg::DimW +: ct_pkg::DimW];
        res_next.out_value  = ent_rdata[63:0];
        res_next.last_entry = (cursor + 1'b1 == loaded);
        res_next.status     = ct_pkg::ST_OK;
        cursor_next         = cursor + 1'b1;
        state_next          = ct_pkg::S_IDLE;
      end

      ct_pkg::S_Q_RD: begin
        res_set              = 1'b1;
        res_next.row_pointer = rs_rdata;
        res_next.status      = ct_pkg::ST_OK;
        state_next           = ct_pkg::S_IDLE;
      end

      default: state_next = ct_pkg::S_IDLE;
    endcase

    // Register writes clear the matrix
    if (cfg_we) begin
      if (cfg_index == ct_pkg::REG_ROW_COUNT) row_count_next = cfg_data;
      else                                    col_count_next = cfg_data;
      loaded_next = '0;
      cursor_next = '0;
      built_next  = 1'b0;
      cidx_next   = '0;
      state_next  = ct_pkg::S_CLR;
    end
  end

endmodule

@@ rtl/core/csr_matrix_transpose.sv @@
// Top level of the compressed-row sparse matrix transpose block.
//
// Input channel in_valid/in_ready/in_data carries one op per beat: load a
// nonzero, fetch the next transposed entry, read a transposed row pointer,
// or clear. Every op gives exactly one result beat on out_valid/out_ready/
// out_data. cfg_we/cfg_index/cfg_data writes row_count or col_count and
// clears the matrix; write only while the block is idle.
// A two-beat queue takes input beats while the back end works. In the back
// end, a load answers at accept if out of range or full, else from the count
// update state; a clear answers at accept, then zeroes all 1024 column
// counts; a fetch runs exec, slot read and entry read; a pointer read runs
// exec and pointer read. The first fetch or pointer read after loading adds
// a build pass: a prefix sum over every column (read, then write) and a
// placement pass over each entry (read it, read its fill pointer, place
// it), set by the single read port of each memory. One op is in the back
// end at a time. After reset the block zeroes all 1024 column counts before
// it takes an op from its queue. A stalled result holds in the output
// register and the back end takes no further op until it is taken.
module csr_matrix_transpose (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  ct_pkg::in_t             in_data,
  output logic                    out_valid,
  input  logic                    out_ready,
  output ct_pkg::out_t            out_data,
  input  logic                    cfg_we,
  input  logic [ct_pkg::IdxW-1:0] cfg_index,
  input  logic [ct_pkg::RegW-1:0] cfg_data
);

  logic        q_valid;
  logic        q_ready;
  ct_pkg::in_t q_data;

  ct_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_data   (q_data)
  );

  ct_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_data    (q_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
